/* sv/hsv_pkg.sv */
// Shared types and constants of the HSV to RGB converter.
package hsv_pkg;

  // Field widths
  localparam int HUE_W   = 13;
  localparam int CH_W    = 8;
  localparam int SECT_W  = 3;
  localparam int OFS_W   = 10;
  localparam int PROD_W  = 18;
  localparam int NUM_W   = 26;
  localparam int RECIP_W = 17;
  localparam int PR_W    = NUM_W + RECIP_W;

  // Stream packing
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  // Hue scale: sixteenths of a degree, 60 degrees per sector
  localparam logic [HUE_W-1:0]  HUE_FULL   = 13'd5760;
  localparam logic [OFS_W-1:0]  HUE_SECTOR = 10'd960;

  // Common denominator 255 * 960 and its reciprocal scaled by 2^34
  localparam logic [PROD_W-1:0]  FIX_DEN     = 18'd244800;
  localparam logic [RECIP_W-1:0] RECIP       = 17'd70179;
  localparam int                 RECIP_SHIFT = 34;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Sector codes
  localparam logic [SECT_W-1:0] SECT_0 = 3'd0;
  localparam logic [SECT_W-1:0] SECT_1 = 3'd1;
  localparam logic [SECT_W-1:0] SECT_2 = 3'd2;
  localparam logic [SECT_W-1:0] SECT_3 = 3'd3;
  localparam logic [SECT_W-1:0] SECT_4 = 3'd4;
  localparam logic [SECT_W-1:0] SECT_5 = 3'd5;

  // Component lanes in the back end
  localparam int LANES  = 3;
  localparam int LANE_P = 0;
  localparam int LANE_Q = 1;
  localparam int LANE_T = 2;

  // Classified pixel as it travels through the queue
  typedef struct packed {
    logic [SECT_W-1:0] sector;
    logic [OFS_W-1:0]  offset;
    logic [CH_W-1:0]   sat;
    logic [CH_W-1:0]   val;
  } hsv_item_t;

endpackage

/* sv/hsv_to_rgb_converter.sv */
// Top level of the HSV to RGB pixel converter.
//
// Input stream s_*: one HSV pixel per beat. Output stream m_*: one RGB pixel
// per input beat, in the same order. Hue is in sixteenths of a degree (values
// above 5760 clamp to 5760), saturation and value are 8-bit fractions.
//
// Throughput: one pixel per clock when nothing stalls. An accepted pixel passes
// through the front queue, then through the multiply, reciprocal divide and
// sector select stages before m_tvalid rises.
//
// The front end classifies hue into sector and offset and writes a four-entry
// queue; s_tready drops only when that queue is full. The back-end pipeline
// moves as a whole and freezes while m_tvalid is high and m_tready is low, so
// a stalled beat holds steady; the queue keeps taking pixels meanwhile.
//
// Reset (rst, synchronous) empties the queue and clears all valid flags.
module hsv_to_rgb_converter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [12:0] hue, [20:13] saturation, [28:21] brightness, [31:29] zero
  input  logic [hsv_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic [hsv_pkg::OUT_TDATA_W-1:0] m_tdata
);

  hsv_pkg::hsv_item_t       front_item;
  hsv_pkg::hsv_item_t       queue_item;
  logic                     queue_valid;
  logic                     back_ready;
  logic [hsv_pkg::CH_W-1:0] red;
  logic [hsv_pkg::CH_W-1:0] green;
  logic [hsv_pkg::CH_W-1:0] blue;

  // Classify
  hsv_front u_front (
    .hue        (s_tdata[12:0]),
    .saturation (s_tdata[20:13]),
    .brightness (s_tdata[28:21]),
    .item       (front_item)
  );

  // Decoupling queue
  hsv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (front_item),
    .out_valid (queue_valid),
    .out_ready (back_ready),
    .out_item  (queue_item)
  );

  // Arithmetic and output register
  hsv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (queue_valid),
    .in_ready  (back_ready),
    .in_item   (queue_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  assign m_tdata = {blue, green, red};

endmodule

/* sv/hsv_front.sv */
// Front end: clamps hue and splits it into sector and offset within the sector.
module hsv_front (
  input  logic [hsv_pkg::HUE_W-1:0] hue,
  input  logic [hsv_pkg::CH_W-1:0]  saturation,
  input  logic [hsv_pkg::CH_W-1:0]  brightness,
  output hsv_pkg::hsv_item_t        item
);

  logic [hsv_pkg::SECT_W-1:0] sector;
  logic [hsv_pkg::HUE_W-1:0]  base;

  // Sector by threshold compare; full circle and beyond fold to sector 0
  always_comb begin
    if (hue >= hsv_pkg::HUE_FULL) begin
      sector = hsv_pkg::SECT_0;
      base   = hue;
    end else if (hue >= hsv_pkg::HUE_W'(5 * hsv_pkg::HUE_SECTOR)) begin
      sector = hsv_pkg::SECT_5;
      base   = hsv_pkg::HUE_W'(5 * hsv_pkg::HUE_SECTOR);
    end else if (hue >= hsv_pkg::HUE_W'(4 * hsv_pkg::HUE_SECTOR)) begin
      sector = hsv_pkg::SECT_4;
      base   = hsv_pkg::HUE_W'(4 * hsv_pkg::HUE_SECTOR);
    end else if (hue >= hsv_pkg::HUE_W'(3 * hsv_pkg::HUE_SECTOR)) begin
      sector = hsv_pkg::SECT_3;
      base   = hsv_pkg::HUE_W'(3 * hsv_pkg::HUE_SECTOR);
    end else if (hue >= hsv_pkg::HUE_W'(2 * hsv_pkg::HUE_SECTOR)) begin
      sector = hsv_pkg::SECT_2;
      base   = hsv_pkg::HUE_W'(2 * hsv_pkg::HUE_SECTOR);
    end else if (hue >= hsv_pkg::HUE_W'(hsv_pkg::HUE_SECTOR)) begin
      sector = hsv_pkg::SECT_1;
      base   = hsv_pkg::HUE_W'(hsv_pkg::HUE_SECTOR);
    end else begin
      sector = hsv_pkg::SECT_0;
      base   = '0;
    end
  end

  // Pack the classified pixel
  always_comb begin
    item.sector = sector;
    item.offset = hsv_pkg::OFS_W'(hue - base);
    item.sat    = saturation;
    item.val    = brightness;
  end

endmodule

/* sv/hsv_queue.sv */
// Short FIFO that decouples the front end from the arithmetic back end.
module hsv_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hsv_pkg::hsv_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output hsv_pkg::hsv_item_t out_item
);

  hsv_pkg::hsv_item_t         slots [hsv_pkg::QUEUE_DEPTH];
  logic [hsv_pkg::QPTR_W-1:0] wr_ptr;
  logic [hsv_pkg::QPTR_W-1:0] rd_ptr;
  logic [hsv_pkg::QCNT_W-1:0] count;
  logic                       push;
  logic                       pop;

  assign in_ready  = (count != hsv_pkg::QCNT_W'(hsv_pkg::QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_item;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= hsv_pkg::QCNT_W'(hsv_pkg::QUEUE_DEPTH))
    else $error("queue fill level above depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    hsv_pkg::QPTR_W'(wr_ptr - rd_ptr) == hsv_pkg::QPTR_W'(count))
    else $error("queue pointers disagree with fill level");
  a_full_stays: assert property (@(posedge clk) disable iff (rst)
    (!in_ready && !pop) |=> !in_ready)
    else $error("full queue drained without a read");
`endif

endmodule

/* sv/hsv_back.sv */
// Back end: five-stage pipeline forming p, q, t and selecting RGB by sector.
module hsv_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  hsv_pkg::hsv_item_t       in_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [hsv_pkg::CH_W-1:0] red,
  output logic [hsv_pkg::CH_W-1:0] green,
  output logic [hsv_pkg::CH_W-1:0] blue
);

  logic en;
  logic v1, v2, v3, v4;

  logic [hsv_pkg::SECT_W-1:0] sector1, sector2, sector3, sector4;
  logic [hsv_pkg::CH_W-1:0]   val1, val2, val3, val4;

  logic [hsv_pkg::PROD_W-1:0] sk  [hsv_pkg::LANES];
  logic [hsv_pkg::NUM_W-1:0]  x2  [hsv_pkg::LANES];
  logic [hsv_pkg::NUM_W-1:0]  x3  [hsv_pkg::LANES];
  logic [hsv_pkg::NUM_W-1:0]  x4  [hsv_pkg::LANES];
  logic [hsv_pkg::PR_W-1:0]   pr  [hsv_pkg::LANES];
  logic [hsv_pkg::CH_W-1:0]   qe  [hsv_pkg::LANES];
  logic [hsv_pkg::NUM_W-1:0]  fq  [hsv_pkg::LANES];
  logic [hsv_pkg::NUM_W-1:0]  diff [hsv_pkg::LANES];
  logic [hsv_pkg::CH_W-1:0]   comp [hsv_pkg::LANES];

  // Whole pipeline advances unless the output beat is stalled
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  // Sector and value ride along
  always_ff @(posedge clk) begin
    if (en) begin
      sector1 <= in_item.sector;
      sector2 <= sector1;
      sector3 <= sector2;
      sector4 <= sector3;
      val1    <= in_item.val;
      val2    <= val1;
      val3    <= val2;
      val4    <= val3;
    end
  end

  // Stage 1: saturation times the k of each component
  always_ff @(posedge clk) begin
    if (en) begin
      sk[hsv_pkg::LANE_P] <= hsv_pkg::PROD_W'(in_item.sat) *
                             hsv_pkg::PROD_W'(hsv_pkg::HUE_SECTOR);
      sk[hsv_pkg::LANE_Q] <= hsv_pkg::PROD_W'(in_item.sat) *
                             hsv_pkg::PROD_W'(in_item.offset);
      sk[hsv_pkg::LANE_T] <= hsv_pkg::PROD_W'(in_item.sat) *
                             hsv_pkg::PROD_W'(hsv_pkg::HUE_SECTOR - in_item.offset);
    end
  end

  // Stages 2 to 4: numerator, reciprocal product, quotient estimate back-multiplied
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < hsv_pkg::LANES; l++) begin
        x2[l] <= hsv_pkg::NUM_W'(val1) * hsv_pkg::NUM_W'(hsv_pkg::FIX_DEN - sk[l]);
        x3[l] <= x2[l];
        pr[l] <= hsv_pkg::PR_W'(x2[l]) * hsv_pkg::PR_W'(hsv_pkg::RECIP);
        x4[l] <= x3[l];
        qe[l] <= pr[l][hsv_pkg::RECIP_SHIFT +: hsv_pkg::CH_W];
        fq[l] <= hsv_pkg::NUM_W'(pr[l][hsv_pkg::RECIP_SHIFT +: hsv_pkg::CH_W]) *
                 hsv_pkg::NUM_W'(hsv_pkg::FIX_DEN);
      end
    end
  end

  // Stage 5: the estimate is low by at most one; correct it
  always_comb begin
    for (int l = 0; l < hsv_pkg::LANES; l++) begin
      diff[l] = x4[l] - fq[l];
      comp[l] = qe[l] + hsv_pkg::CH_W'(diff[l] >= hsv_pkg::NUM_W'(hsv_pkg::FIX_DEN));
    end
  end

  // Component select by sector into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      unique case (sector4)
        hsv_pkg::SECT_0: begin
          red   <= val4;
          green <= comp[hsv_pkg::LANE_T];
          blue  <= comp[hsv_pkg::LANE_P];
        end
        hsv_pkg::SECT_1: begin
          red   <= comp[hsv_pkg::LANE_Q];
          green <= val4;
          blue  <= comp[hsv_pkg::LANE_P];
        end
        hsv_pkg::SECT_2: begin
          red   <= comp[hsv_pkg::LANE_P];
          green <= val4;
          blue  <= comp[hsv_pkg::LANE_T];
        end
        hsv_pkg::SECT_3: begin
          red   <= comp[hsv_pkg::LANE_P];
          green <= comp[hsv_pkg::LANE_Q];
          blue  <= val4;
        end
        hsv_pkg::SECT_4: begin
          red   <= comp[hsv_pkg::LANE_T];
          green <= comp[hsv_pkg::LANE_P];
          blue  <= val4;
        end
        default: begin
          red   <= val4;
          green <= comp[hsv_pkg::LANE_P];
          blue  <= comp[hsv_pkg::LANE_Q];
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_est_range: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (pr[hsv_pkg::LANE_P][hsv_pkg::PR_W-1] == 1'b0 &&
            pr[hsv_pkg::LANE_Q][hsv_pkg::PR_W-1] == 1'b0 &&
            pr[hsv_pkg::LANE_T][hsv_pkg::PR_W-1] == 1'b0))
    else $error("quotient estimate above 8 bits");
  a_corr_range: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (diff[hsv_pkg::LANE_P] < hsv_pkg::NUM_W'(2 * hsv_pkg::FIX_DEN) &&
            diff[hsv_pkg::LANE_Q] < hsv_pkg::NUM_W'(2 * hsv_pkg::FIX_DEN) &&
            diff[hsv_pkg::LANE_T] < hsv_pkg::NUM_W'(2 * hsv_pkg::FIX_DEN)))
    else $error("quotient estimate off by more than one");
`endif

endmodule
